FILE: design/lbp_pkg.sv
`default_nettype none

package lbp_pkg;

    // Command codes carried in the input beat's tuser.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_OFF   = 3'd1;
    localparam logic [2:0] CMD_ON    = 3'd2;
    localparam logic [2:0] CMD_TMO   = 3'd3;
    localparam logic [2:0] CMD_SLOW  = 3'd4;
    localparam logic [2:0] CMD_FAST  = 3'd5;
    localparam logic [2:0] CMD_BURST = 3'd6;

    // Mode codes reported in the result beat.
    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_ON    = 3'd1;
    localparam logic [2:0] MODE_SLOW  = 3'd2;
    localparam logic [2:0] MODE_FAST  = 3'd3;
    localparam logic [2:0] MODE_BURST = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_SLOW_HALF  = 2'd0;
    localparam logic [1:0] CFG_FAST_HALF  = 2'd1;
    localparam logic [1:0] CFG_BURST_STEP = 2'd2;
    localparam logic [1:0] CFG_BURST_GAP  = 2'd3;

    localparam logic [15:0] RST_SLOW_HALF  = 16'd250;
    localparam logic [15:0] RST_FAST_HALF  = 16'd50;
    localparam logic [15:0] RST_BURST_STEP = 16'd100;
    localparam logic [15:0] RST_BURST_GAP  = 16'd500;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CMD_W       = 3;
    localparam int MODE_W      = 3;
    localparam int PHASE_W     = 3;
    localparam int TMO_FIELD_W = 32;
    localparam int OUT_DATA_W  = 8;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] slow_half;
        logic [CFG_DATA_W-1:0] fast_half;
        logic [CFG_DATA_W-1:0] burst_step;
        logic [CFG_DATA_W-1:0] burst_gap;
    } t_cfg;

    typedef struct packed {
        logic              busy;
        logic [MODE_W-1:0] mode;
        logic              led;
    } t_result;

endpackage

`default_nettype wire

FILE: design/lbp_cfg.sv
`default_nettype none

module lbp_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0]   i_index,
    input  wire logic [lbp_pkg::CFG_DATA_W-1:0]  i_data,
    output lbp_pkg::t_cfg                        o_cfg
);

    lbp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_half  <= lbp_pkg::RST_SLOW_HALF;
            r_cfg.fast_half  <= lbp_pkg::RST_FAST_HALF;
            r_cfg.burst_step <= lbp_pkg::RST_BURST_STEP;
            r_cfg.burst_gap  <= lbp_pkg::RST_BURST_GAP;
        end else if (i_wr) begin
            unique case (i_index)
                lbp_pkg::CFG_SLOW_HALF:  r_cfg.slow_half  <= i_data;
                lbp_pkg::CFG_FAST_HALF:  r_cfg.fast_half  <= i_data;
                lbp_pkg::CFG_BURST_STEP: r_cfg.burst_step <= i_data;
                lbp_pkg::CFG_BURST_GAP:  r_cfg.burst_gap  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: design/lbp_core.sv
`default_nettype none

module lbp_core #(
    parameter int TIMEOUT_BITS     = 32,
    parameter int PERIOD_BITS      = 16,
    parameter int BURST_LAST_PHASE = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [lbp_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [TIMEOUT_BITS-1:0]     i_tmo,
    input  wire lbp_pkg::t_cfg               i_cfg,
    output lbp_pkg::t_result                 o_result
);

    localparam logic [lbp_pkg::PHASE_W-1:0] LAST_PHASE =
        lbp_pkg::PHASE_W'(BURST_LAST_PHASE);

    logic [lbp_pkg::MODE_W-1:0]  r_mode,  n_mode;
    logic                        r_led,   n_led;
    logic [lbp_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [PERIOD_BITS-1:0]      r_uwait, n_uwait;
    logic [TIMEOUT_BITS-1:0]     r_owait, n_owait;
    logic                        r_armed, n_armed;

    logic [31:0]            w_slow_ext, w_fast_ext, w_step_ext, w_gap_ext;
    logic [PERIOD_BITS-1:0] w_slow, w_fast, w_step, w_gap;
    logic                   w_update;
    logic                   w_enter;
    logic [lbp_pkg::MODE_W-1:0] w_enter_mode;

    // Periods are held to PERIOD_BITS bits.
    assign w_slow_ext = {16'd0, i_cfg.slow_half};
    assign w_fast_ext = {16'd0, i_cfg.fast_half};
    assign w_step_ext = {16'd0, i_cfg.burst_step};
    assign w_gap_ext  = {16'd0, i_cfg.burst_gap};
    assign w_slow = w_slow_ext[PERIOD_BITS-1:0];
    assign w_fast = w_fast_ext[PERIOD_BITS-1:0];
    assign w_step = w_step_ext[PERIOD_BITS-1:0];
    assign w_gap  = w_gap_ext[PERIOD_BITS-1:0];

    always_comb begin
        n_mode   = r_mode;
        n_led    = r_led;
        n_phase  = r_phase;
        n_uwait  = r_uwait;
        n_owait  = r_owait;
        n_armed  = r_armed;
        w_update = 1'b0;
        w_enter  = 1'b0;
        w_enter_mode = lbp_pkg::MODE_OFF;

        unique case (i_cmd)
            lbp_pkg::CMD_TICK: begin
                if (r_mode != lbp_pkg::MODE_OFF) begin
                    if (r_armed && (r_owait == '0)) begin
                        w_enter      = 1'b1;
                        w_enter_mode = lbp_pkg::MODE_OFF;
                    end else begin
                        if (r_armed) begin
                            n_owait = r_owait - TIMEOUT_BITS'(1);
                        end
                        if (r_uwait == '0) begin
                            w_update = 1'b1;
                        end else begin
                            n_uwait = r_uwait - PERIOD_BITS'(1);
                        end
                    end
                end
            end
            lbp_pkg::CMD_OFF: begin
                w_enter      = 1'b1;
                w_enter_mode = lbp_pkg::MODE_OFF;
            end
            lbp_pkg::CMD_ON, lbp_pkg::CMD_TMO: begin
                w_enter      = 1'b1;
                w_enter_mode = lbp_pkg::MODE_ON;
            end
            lbp_pkg::CMD_SLOW: begin
                w_enter      = 1'b1;
                w_enter_mode = lbp_pkg::MODE_SLOW;
            end
            lbp_pkg::CMD_FAST: begin
                w_enter      = 1'b1;
                w_enter_mode = lbp_pkg::MODE_FAST;
            end
            lbp_pkg::CMD_BURST: begin
                w_enter      = 1'b1;
                w_enter_mode = lbp_pkg::MODE_BURST;
            end
            default: ;
        endcase

        // Entering a mode resets everything and runs the first update at once.
        if (w_enter) begin
            n_armed  = 1'b0;
            n_owait  = '0;
            n_led    = (w_enter_mode == lbp_pkg::MODE_ON);
            n_uwait  = '0;
            n_phase  = '0;
            n_mode   = w_enter_mode;
            w_update = 1'b1;
        end

        if (w_update) begin
            unique case (n_mode)
                lbp_pkg::MODE_SLOW: begin
                    n_uwait = w_slow;
                    n_led   = ~n_led;
                end
                lbp_pkg::MODE_FAST: begin
                    n_uwait = w_fast;
                    n_led   = ~n_led;
                end
                lbp_pkg::MODE_BURST: begin
                    n_led = ~n_phase[0];
                    if (n_phase < LAST_PHASE) begin
                        n_uwait = w_step;
                        n_phase = n_phase + lbp_pkg::PHASE_W'(1);
                    end else begin
                        n_uwait = w_gap;
                        n_phase = '0;
                    end
                end
                default: begin
                    n_uwait = '0;
                end
            endcase
        end

        if (i_cmd == lbp_pkg::CMD_TMO) begin
            n_owait = i_tmo;
            n_armed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lbp_pkg::MODE_OFF;
            r_led   <= 1'b0;
            r_phase <= '0;
            r_uwait <= '0;
            r_owait <= '0;
            r_armed <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_led   <= n_led;
            r_phase <= n_phase;
            r_uwait <= n_uwait;
            r_owait <= n_owait;
            r_armed <= n_armed;
        end
    end

    assign o_result.led  = n_led;
    assign o_result.mode = n_mode;
    assign o_result.busy = n_armed || (n_mode == lbp_pkg::MODE_SLOW) ||
                           (n_mode == lbp_pkg::MODE_FAST) ||
                           (n_mode == lbp_pkg::MODE_BURST);

endmodule

`default_nettype wire

FILE: design/led_blink_pattern_controller.sv
// LED blink pattern controller. Each input beat carries a command in tuser
// (tick, off, on, on with timeout, slow blink, fast blink, burst) and a
// timeout in tdata, and produces exactly one result beat with the LED level,
// the current mode and a busy flag. A beat is registered on entry, then the
// mode state is updated and the result is formed in one pass of short logic
// into the output register, so the block takes one beat per clock cycle;
// the only thing that slows it is back-pressure on the result side. Ticks
// are expected once per millisecond, so every period register counts in
// milliseconds. The user must write the four period registers through the
// configuration port only while no beat is in flight; the block does not
// enforce this. They reset to 250, 50, 100 and 500.
`default_nettype none

module led_blink_pattern_controller #(
    parameter int TIMEOUT_BITS     = 32,
    parameter int PERIOD_BITS      = 16,
    parameter int BURST_LAST_PHASE = 5
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Command stream.
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // tdata: timeout_ms [31:0]
    input  wire logic [lbp_pkg::TMO_FIELD_W-1:0]     i_s_tdata,
    // tuser: cmd [2:0]
    input  wire logic [lbp_pkg::CMD_W-1:0]           i_s_tuser,
    // Result stream.
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // tdata: led_lit [0], mode_now [3:1], busy_res [4], zero [7:5]
    output logic [lbp_pkg::OUT_DATA_W-1:0]           o_m_tdata,
    // Configuration writes.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [lbp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic                          r_in_valid;
    logic [lbp_pkg::CMD_W-1:0]     r_in_cmd;
    logic [TIMEOUT_BITS-1:0]       r_in_tmo;
    logic                          r_out_valid;
    lbp_pkg::t_result              r_out;

    logic                          w_out_adv;
    logic                          w_step;
    lbp_pkg::t_cfg                 w_cfg;
    lbp_pkg::t_result              w_result;

    // The output register moves whenever it is empty or being drained; the
    // input register refills whenever its beat moves on.
    assign w_out_adv  = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_out_adv;
    assign o_s_tready = !r_in_valid || w_out_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Only the low TIMEOUT_BITS bits of the timeout take part.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd <= i_s_tuser;
            r_in_tmo <= i_s_tdata[TIMEOUT_BITS-1:0];
        end
    end

    lbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    lbp_core #(
        .TIMEOUT_BITS     (TIMEOUT_BITS),
        .PERIOD_BITS      (PERIOD_BITS),
        .BURST_LAST_PHASE (BURST_LAST_PHASE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_cmd    (r_in_cmd),
        .i_tmo    (r_in_tmo),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.busy, r_out.mode, r_out.led};

    // A held input beat must not change while the result side is stalled.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_adv) |=> ($stable(r_in_cmd) && $stable(r_in_tmo)))
        else $error("input register changed while stalled");

    // In off mode the LED is dark and nothing is pending.
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.mode == lbp_pkg::MODE_OFF)) |-> (!r_out.led && !r_out.busy))
        else $error("off mode reports lit LED or busy");

    // Blink and burst modes always report busy.
    a_blink_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out.mode == lbp_pkg::MODE_SLOW) ||
                         (r_out.mode == lbp_pkg::MODE_FAST) ||
                         (r_out.mode == lbp_pkg::MODE_BURST))) |-> r_out.busy)
        else $error("blink mode without busy");

    // A burst command lights the LED at once.
    a_burst_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_in_cmd == lbp_pkg::CMD_BURST)) |=> r_out.led)
        else $error("burst did not start lit");

endmodule

`default_nettype wire

FILE: tb/tb_led_blink_pattern_controller.sv
`default_nettype none

module tb_led_blink_pattern_controller;

    // Pattern constants that the block was built with (its defaults).
    localparam int BURST_LAST_PHASE = 5;
    // The command field is three bits wide, so one code is left unused.
    localparam logic [2:0] CMD_SPARE = 3'd7;
    // Drain slack after the last result; the block holds an input and an output register.
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_SETTING = 108;

    // Register indexes in the order the write task walks them.
    localparam logic [lbp_pkg::CFG_IDX_W-1:0] REG_ORDER [4] =
        '{lbp_pkg::CFG_SLOW_HALF, lbp_pkg::CFG_FAST_HALF,
          lbp_pkg::CFG_BURST_STEP, lbp_pkg::CFG_BURST_GAP};

    // Keeps a copy of the blink state, works out the result beat that each
    // accepted command must cause, and checks result beats in order.
    class blink_scoreboard;
        logic [15:0] slow_half, fast_half, burst_step, burst_gap;
        logic [2:0]  mode;
        logic        led;
        logic [2:0]  phase;
        logic [15:0] upd_wait;
        logic [31:0] off_wait;
        logic        off_armed;
        lbp_pkg::t_result results_due[$];
        int          mismatches;
        int          results_seen;

        function new();
            slow_half  = lbp_pkg::RST_SLOW_HALF;
            fast_half  = lbp_pkg::RST_FAST_HALF;
            burst_step = lbp_pkg::RST_BURST_STEP;
            burst_gap  = lbp_pkg::RST_BURST_GAP;
            mode       = lbp_pkg::MODE_OFF;
            led        = 1'b0;
            phase      = '0;
            upd_wait   = '0;
            off_wait   = '0;
            off_armed  = 1'b0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [lbp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                lbp_pkg::CFG_SLOW_HALF:  slow_half  = val;
                lbp_pkg::CFG_FAST_HALF:  fast_half  = val;
                lbp_pkg::CFG_BURST_STEP: burst_step = val;
                lbp_pkg::CFG_BURST_GAP:  burst_gap  = val;
                default: ;
            endcase
        endfunction

        // One pattern step: blink modes toggle, the burst lights on even
        // phases and picks the short or the long wait.
        function void pattern_step();
            case (mode)
                lbp_pkg::MODE_SLOW: begin
                    upd_wait = slow_half;
                    led = ~led;
                end
                lbp_pkg::MODE_FAST: begin
                    upd_wait = fast_half;
                    led = ~led;
                end
                lbp_pkg::MODE_BURST: begin
                    led = ~phase[0];
                    if (phase < 3'(BURST_LAST_PHASE)) begin
                        upd_wait = burst_step;
                        phase = phase + 3'd1;
                    end else begin
                        upd_wait = burst_gap;
                        phase = '0;
                    end
                end
                default: upd_wait = '0;
            endcase
        endfunction

        function void switch_mode(logic [2:0] m);
            off_armed = 1'b0;
            off_wait  = '0;
            led       = (m == lbp_pkg::MODE_ON);
            upd_wait  = '0;
            phase     = '0;
            mode      = m;
            pattern_step();
        endfunction

        function void ms_tick();
            if (mode == lbp_pkg::MODE_OFF) return;
            if (off_armed) begin
                if (off_wait == '0) begin
                    switch_mode(lbp_pkg::MODE_OFF);
                    return;
                end
                off_wait = off_wait - 32'd1;
            end
            if (upd_wait == '0) pattern_step();
            else upd_wait = upd_wait - 16'd1;
        endfunction

        function void note_command(logic [2:0] cmd, logic [31:0] tmo);
            lbp_pkg::t_result r;
            case (cmd)
                lbp_pkg::CMD_TICK:  ms_tick();
                lbp_pkg::CMD_OFF:   switch_mode(lbp_pkg::MODE_OFF);
                lbp_pkg::CMD_ON:    switch_mode(lbp_pkg::MODE_ON);
                lbp_pkg::CMD_TMO: begin
                    switch_mode(lbp_pkg::MODE_ON);
                    off_wait  = tmo;
                    off_armed = 1'b1;
                end
                lbp_pkg::CMD_SLOW:  switch_mode(lbp_pkg::MODE_SLOW);
                lbp_pkg::CMD_FAST:  switch_mode(lbp_pkg::MODE_FAST);
                lbp_pkg::CMD_BURST: switch_mode(lbp_pkg::MODE_BURST);
                default: ;
            endcase
            r.led  = led;
            r.mode = mode;
            r.busy = off_armed || mode == lbp_pkg::MODE_SLOW ||
                     mode == lbp_pkg::MODE_FAST || mode == lbp_pkg::MODE_BURST;
            results_due.push_back(r);
        endfunction

        function void check_result(logic [lbp_pkg::OUT_DATA_W-1:0] data);
            lbp_pkg::t_result due;
            lbp_pkg::t_result got;
            results_seen++;
            if (results_due.size() == 0) begin
                $error("result beat 0x%02h arrived with no command waiting", data);
                mismatches++;
                return;
            end
            due = results_due.pop_front();
            got = lbp_pkg::t_result'(data[$bits(lbp_pkg::t_result)-1:0]);
            if (got.led !== due.led) begin
                $error("led_lit: expected %0d, got %0d", due.led, got.led);
                mismatches++;
            end
            if (got.mode !== due.mode) begin
                $error("mode_now: expected %0d, got %0d", due.mode, got.mode);
                mismatches++;
            end
            if (got.busy !== due.busy) begin
                $error("busy_res: expected %0d, got %0d", due.busy, got.busy);
                mismatches++;
            end
            if (data[lbp_pkg::OUT_DATA_W-1:$bits(lbp_pkg::t_result)] !== '0) begin
                $error("padding: expected 0, got 0x%0h",
                       data[lbp_pkg::OUT_DATA_W-1:$bits(lbp_pkg::t_result)]);
                mismatches++;
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_s_tvalid;
    logic                               o_s_tready;
    logic [lbp_pkg::TMO_FIELD_W-1:0]    i_s_tdata;
    logic [lbp_pkg::CMD_W-1:0]          i_s_tuser;
    logic                               o_m_tvalid;
    logic                               i_m_tready;
    logic [lbp_pkg::OUT_DATA_W-1:0]     o_m_tdata;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [lbp_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [lbp_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    blink_scoreboard sb;

    // Sender burst state, and the counters for the closing summary.
    int burst_left = 0;
    int cmds_sent = 0;
    int ticks_sent = 0;
    int settings_used = 1;
    int cycle_count = 0;

    // Receiver stall pattern state.
    int stall_style = 0;
    int style_left = 0;
    int stall_hold = 0;
    int pattern_cnt = 0;

    led_blink_pattern_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Every beat is recorded at the edge that accepts it. Commands are noted
    // before results are checked, although a command passes the input and output
    // registers first, so its result never comes at the edge that took it. The
    // receiver's tready is driven only from here, one assignment per edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_command(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        end
        // Each stretch of the run draws a stall style at random: always ready,
        // coin flips, a fixed one-in-three stall, or long random holds.
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(20, 80);
        end
        style_left--;
        pattern_cnt++;
        case (stall_style)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= (pattern_cnt % 3 != 0);
            default: begin
                if (stall_hold > 0) begin
                    stall_hold--;
                    i_m_tready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 5) == 0) stall_hold = $urandom_range(1, 8);
                    i_m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Watchdog: a run that stalls past the limit is a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Send one command beat. The sender works in bursts; when a burst runs
    // out, tvalid drops for a random gap before the next beat is offered.
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] tmo);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= tmo;
        do @(posedge i_clk); while (!o_s_tready);
        cmds_sent++;
        if (cmd == lbp_pkg::CMD_TICK) ticks_sent++;
    endtask

    // Stop sending and wait until every result is in, then let the pipeline
    // settle so a register write cannot overlap a beat in flight.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four period registers back to back; valid stays high across
    // the beats and drops after the last one.
    task automatic write_periods(input logic [3:0][15:0] vals);
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_ORDER[r];
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_register(REG_ORDER[r], vals[r]);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random traffic: mostly ticks so that modes get to run and time out,
    // with mode changes, timed-on commands and the unused code mixed in.
    task automatic random_traffic(input int count);
        int pick;
        logic [2:0] cmd;
        logic [31:0] tmo;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            tmo = $urandom;
            if (pick < 65) cmd = lbp_pkg::CMD_TICK;
            else if (pick < 70) cmd = lbp_pkg::CMD_OFF;
            else if (pick < 74) cmd = lbp_pkg::CMD_ON;
            else if (pick < 84) begin
                cmd = lbp_pkg::CMD_TMO;
                pick = $urandom_range(0, 19);
                // Short timeouts expire within the run; a few are huge.
                if (pick < 16) tmo = $urandom_range(0, 15);
                else if (pick < 19) tmo = $urandom_range(16, 200);
            end
            else if (pick < 88) cmd = lbp_pkg::CMD_SLOW;
            else if (pick < 92) cmd = lbp_pkg::CMD_FAST;
            else if (pick < 97) cmd = lbp_pkg::CMD_BURST;
            else cmd = CMD_SPARE;
            send_command(cmd, tmo);
            // Halfway through, hold off until the result side has caught up.
            if (i == count / 2) wait_drained();
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= lbp_pkg::CMD_TICK;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= lbp_pkg::CFG_SLOW_HALF;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset periods.
        // A tick and the unused code while off change nothing.
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        send_command(CMD_SPARE, 32'hFFFF_FFFF);
        // Plain on ignores the timeout field, and a tick leaves it lit.
        send_command(lbp_pkg::CMD_ON, 32'hFFFF_FFFF);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        // A zero timeout turns the LED off on the very first tick.
        send_command(lbp_pkg::CMD_TMO, 32'h0);
        send_command(lbp_pkg::CMD_TICK, 32'hFFFF_FFFF);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        // A timeout of two turns it off on the third tick.
        send_command(lbp_pkg::CMD_TMO, 32'd2);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        // The largest timeout counts down from all ones.
        send_command(lbp_pkg::CMD_TMO, 32'hFFFF_FFFF);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        send_command(CMD_SPARE, 32'h0);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        // Each blink mode lights at once; a command clears the armed timeout.
        send_command(lbp_pkg::CMD_SLOW, 32'hA5A5_5A5A);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        send_command(lbp_pkg::CMD_FAST, 32'h5A5A_A5A5);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        send_command(lbp_pkg::CMD_BURST, 32'h0);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        send_command(lbp_pkg::CMD_OFF, 32'hFFFF_FFFF);
        send_command(lbp_pkg::CMD_TICK, 32'h0);
        wait_drained();

        // Zero periods: every tick updates the pattern.
        write_periods({16'd0, 16'd0, 16'd0, 16'd0});
        random_traffic(RANDOM_PER_SETTING);
        wait_drained();

        // Short random periods so blinks and bursts wrap many times.
        write_periods({16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                       16'($urandom_range(0, 5)), 16'($urandom_range(0, 5))});
        random_traffic(RANDOM_PER_SETTING);
        wait_drained();

        // Largest periods: patterns hold their first level for the run.
        write_periods({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        random_traffic(RANDOM_PER_SETTING);
        wait_drained();

        // Mixed short steps and a longer gap after the last burst phase.
        write_periods({16'($urandom_range(4, 12)), 16'($urandom_range(1, 3)),
                       16'($urandom_range(0, 3)), 16'($urandom_range(0, 9))});
        random_traffic(RANDOM_PER_SETTING);
        wait_drained();

        $display("Sent %0d command beats (%0d of them ticks) over %0d period settings,",
                 cmds_sent, ticks_sent, settings_used);
        $display("and compared %0d result beats against the predicted LED state.",
                 sb.results_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
design/lbp_pkg.sv
design/lbp_cfg.sv
design/lbp_core.sv
design/led_blink_pattern_controller.sv
tb/tb_led_blink_pattern_controller.sv
